/* rtl/dual_table_linear_interpolator_unit_macros.svh */
// Assertion macros used by the interpolator top level.
`ifndef DUAL_TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define DUAL_TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTLI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dtli_pkg.sv */
// Shared constants, codes and types of the dual table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package dtli_pkg;

  // Data width of every Q16.16 value
  localparam int DTLI_W = 32;

  // Default table depth
  localparam int DTLI_MAX_POINTS = 32;

  typedef logic signed [DTLI_W-1:0] q16_t;

  // Action codes of an input item
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAP_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_DEF_EFF      = 2'd1;
  localparam logic [1:0] CFG_DEF_LOSS     = 2'd2;

  // Reset values of the default outputs (0.99 and 0.04)
  localparam q16_t DEF_EFF_RST  = 32'sd64881;
  localparam q16_t DEF_LOSS_RST = 32'sd2621;

endpackage
`default_nettype wire

/* rtl/dtli_if.sv */
// Handshake channel interfaces: input items, result items, configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface dtli_in_if;
  import dtli_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       table_select;
  q16_t       point_x;
  q16_t       point_y;
  q16_t       fuel_air_ratio;
  q16_t       corrected_flow;

  modport source (output valid, action, table_select, point_x, point_y,
                  fuel_air_ratio, corrected_flow, input ready);
  modport sink (input valid, action, table_select, point_x, point_y,
                fuel_air_ratio, corrected_flow, output ready);
endinterface

interface dtli_out_if;
  import dtli_pkg::*;
  logic valid;
  logic ready;
  logic status;
  q16_t efficiency;
  q16_t pressure_loss;

  modport source (output valid, status, efficiency, pressure_loss, input ready);
  modport sink (input valid, status, efficiency, pressure_loss, output ready);
endinterface

interface dtli_cfg_if;
  import dtli_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [DTLI_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/dtli_table_mem.sv */
// Breakpoint memory: one write port, one registered read port, {x, y} per entry.
`timescale 1ns / 1ps
`default_nettype none
module dtli_table_mem #(
  parameter int DEPTH = dtli_pkg::DTLI_MAX_POINTS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [2*dtli_pkg::DTLI_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr,
  output      logic [2*dtli_pkg::DTLI_W-1:0] rdata
);
  import dtli_pkg::*;

  logic [2*DTLI_W-1:0] mem [DEPTH];
  logic [2*DTLI_W-1:0] rdata_r;

  // Write the new point, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/dtli_divider.sv */
// Restoring divider, one quotient bit per cycle, for quotients known to fit 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module dtli_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [2*dtli_pkg::DTLI_W-1:0] dividend,
  input  wire logic [dtli_pkg::DTLI_W-1:0]   divisor,
  output      logic                          done,
  output      logic [dtli_pkg::DTLI_W-1:0]   quotient
);
  import dtli_pkg::*;

  localparam int CW = $clog2(DTLI_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DTLI_W-1:0] rem_r, rem_nxt;
  logic [DTLI_W-1:0] quo_r, quo_nxt;
  logic [DTLI_W-1:0] div_r, div_nxt;
  logic [DTLI_W:0]   trial;
  logic [DTLI_W:0]   diff;
  logic              take;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quo_r[DTLI_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign take  = (trial >= {1'b0, div_r});

  // The high half of the dividend is below the divisor, so it seeds the
  // remainder and only the low half needs bit steps.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[2*DTLI_W-1:DTLI_W];
      quo_nxt  = dividend[DTLI_W-1:0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = take ? diff[DTLI_W-1:0] : trial[DTLI_W-1:0];
      quo_nxt = {quo_r[DTLI_W-2:0], take};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DTLI_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/dual_table_linear_interpolator_unit.sv */
// Top level: two breakpoint tables, scan sequencer, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_table_linear_interpolator_unit_macros.svh"
// Keeps an efficiency table and a pressure loss table of up to MAX_POINTS
// signed Q16.16 (x, y) points each, and answers one item at a time.
// An append, a clear or an unused action passes from acceptance through
// the dispatch state to the output state, which loads the result register
// once it is free. A query works through the efficiency table and then the
// pressure loss table on one sequencer: per usable table it reads the first
// and last point, scans one segment per cycle through the table memory's
// single read port (up to n-1 segments for n points), and for an interior
// hit forms the 32x32 product in the multiply state, starts the divider and
// waits for the bit-serial divider to finish. A query whose tables both
// fall back to the defaults reads no table point.
// The block takes the next item while a finished result waits at the output.
// Configuration writes are always ready and must be made while idle.
module dual_table_linear_interpolator_unit #(
  parameter int MAX_POINTS = dtli_pkg::DTLI_MAX_POINTS
) (
  input wire logic     clk,
  input wire logic     rst_n,
  dtli_in_if.sink      in_ch,
  dtli_out_if.source   out_ch,
  dtli_cfg_if.sink     cfg_ch
);
  import dtli_pkg::*;

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_TSTART   = 9'b000000100,
    S_TFIRST   = 9'b000001000,
    S_TLAST    = 9'b000010000,
    S_TSCAN    = 9'b000100000,
    S_MUL      = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic map_en_r;
  q16_t def_eff_r;
  q16_t def_loss_r;

  // Captured item
  logic [1:0] action_r;
  logic       tsel_r;
  q16_t       px_r, py_r, far_r, cf_r;

  // Table fill counts
  logic [CNT_W-1:0] eff_cnt_r, eff_cnt_nxt;
  logic [CNT_W-1:0] loss_cnt_r, loss_cnt_nxt;

  // Lookup working registers
  logic          sel_r, sel_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  q16_t          prev_x_r, prev_x_nxt;
  q16_t          prev_y_r, prev_y_nxt;
  q16_t          y0_r, y0_nxt;
  logic [DTLI_W-1:0] dx_r, dx_nxt;
  logic [DTLI_W-1:0] den_r, den_nxt;
  logic [DTLI_W-1:0] mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [2*DTLI_W-1:0] prod_r;
  logic              div_start_r;
  q16_t          eff_res_r, eff_res_nxt;
  q16_t          loss_res_r, loss_res_nxt;
  logic          status_r, status_nxt;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic out_status_r;
  q16_t out_eff_r, out_loss_r;
  logic out_load;

  // Memory ports
  logic                eff_we, loss_we;
  logic [AW-1:0]       rd_addr;
  logic [2*DTLI_W-1:0] eff_rd, loss_rd, rd_data;
  q16_t                rd_x, rd_y;

  // Shared arithmetic
  logic              div_done;
  logic [DTLI_W-1:0] div_q;
  logic [DTLI_W:0]   dx_full, den_full, dy_full, dy_abs;

  // Per-table selections
  q16_t             q_x;
  logic [CNT_W-1:0] cnt_sel;
  logic [CNT_W-1:0] last_full;
  logic [AW-1:0]    last_addr;
  logic             usable;
  logic             seg_hit;

  assign q_x       = sel_r ? cf_r : far_r;
  assign cnt_sel   = sel_r ? loss_cnt_r : eff_cnt_r;
  assign last_full = cnt_sel - CNT_W'(1);
  assign last_addr = last_full[AW-1:0];
  assign usable    = map_en_r && (cnt_sel >= CNT_W'(2));
  assign rd_data   = sel_r ? loss_rd : eff_rd;
  assign rd_x      = signed'(rd_data[2*DTLI_W-1:DTLI_W]);
  assign rd_y      = signed'(rd_data[DTLI_W-1:0]);
  assign seg_hit   = (q_x >= prev_x_r) && (q_x <= rd_x);

  // Segment operands in 33 bits; the hit guarantees dx and den are non-negative
  assign dx_full  = {q_x[DTLI_W-1], q_x} - {prev_x_r[DTLI_W-1], prev_x_r};
  assign den_full = {rd_x[DTLI_W-1], rd_x} - {prev_x_r[DTLI_W-1], prev_x_r};
  assign dy_full  = {rd_y[DTLI_W-1], rd_y} - {prev_y_r[DTLI_W-1], prev_y_r};
  assign dy_abs   = dy_full[DTLI_W] ? (~dy_full + (DTLI_W+1)'(1)) : dy_full;

  // Pick the read address for the next cycle's lookup step
  always_comb begin
    unique case (state_r)
      S_TSTART: rd_addr = '0;
      S_TFIRST: rd_addr = last_addr;
      S_TLAST:  rd_addr = AW'(1);
      S_TSCAN:  rd_addr = idx_r + AW'(1);
      default:  rd_addr = '0;
    endcase
  end

  // Append writes go to the slot at the current fill count
  assign eff_we  = (state_r == S_DISPATCH) && (action_r == ACT_APPEND) && !tsel_r &&
                   (eff_cnt_r < CNT_W'(MAX_POINTS));
  assign loss_we = (state_r == S_DISPATCH) && (action_r == ACT_APPEND) && tsel_r &&
                   (loss_cnt_r < CNT_W'(MAX_POINTS));

  dtli_table_mem #(.DEPTH(MAX_POINTS)) u_eff_mem (
    .clk   (clk),
    .we    (eff_we),
    .waddr (eff_cnt_r[AW-1:0]),
    .wdata ({px_r, py_r}),
    .raddr (rd_addr),
    .rdata (eff_rd)
  );

  dtli_table_mem #(.DEPTH(MAX_POINTS)) u_loss_mem (
    .clk   (clk),
    .we    (loss_we),
    .waddr (loss_cnt_r[AW-1:0]),
    .wdata ({px_r, py_r}),
    .raddr (rd_addr),
    .rdata (loss_rd)
  );

  dtli_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    logic tbl_done;
    q16_t tbl_val;
    tbl_done     = 1'b0;
    tbl_val      = '0;
    state_nxt    = state_r;
    eff_cnt_nxt  = eff_cnt_r;
    loss_cnt_nxt = loss_cnt_r;
    sel_nxt      = sel_r;
    idx_nxt      = idx_r;
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    y0_nxt       = y0_r;
    dx_nxt       = dx_r;
    den_nxt      = den_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    eff_res_nxt  = eff_res_r;
    loss_res_nxt = loss_res_r;
    status_nxt   = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_nxt   = 1'b0;
        eff_res_nxt  = '0;
        loss_res_nxt = '0;
        state_nxt    = S_OUT;
        case (action_r)
          ACT_APPEND: begin
            if (eff_we) begin
              eff_cnt_nxt = eff_cnt_r + CNT_W'(1);
            end else if (loss_we) begin
              loss_cnt_nxt = loss_cnt_r + CNT_W'(1);
            end else begin
              status_nxt = 1'b1;
            end
          end
          ACT_QUERY: begin
            sel_nxt   = 1'b0;
            state_nxt = S_TSTART;
          end
          ACT_CLEAR: begin
            eff_cnt_nxt  = '0;
            loss_cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_TSTART: begin
        if (!usable) begin
          tbl_done = 1'b1;
          tbl_val  = sel_r ? def_loss_r : def_eff_r;
        end else begin
          state_nxt = S_TFIRST;
        end
      end
      S_TFIRST: begin
        // Clamp below the first point
        if (q_x <= rd_x) begin
          tbl_done = 1'b1;
          tbl_val  = rd_y;
        end else begin
          prev_x_nxt = rd_x;
          prev_y_nxt = rd_y;
          state_nxt  = S_TLAST;
        end
      end
      S_TLAST: begin
        // Clamp above the last point
        if (q_x >= rd_x) begin
          tbl_done = 1'b1;
          tbl_val  = rd_y;
        end else begin
          idx_nxt   = AW'(1);
          state_nxt = S_TSCAN;
        end
      end
      S_TSCAN: begin
        if (seg_hit) begin
          if (rd_x == prev_x_r) begin
            tbl_done = 1'b1;
            tbl_val  = prev_y_r;
          end else begin
            dx_nxt    = dx_full[DTLI_W-1:0];
            den_nxt   = den_full[DTLI_W-1:0];
            mag_nxt   = dy_abs[DTLI_W-1:0];
            neg_nxt   = dy_full[DTLI_W];
            y0_nxt    = prev_y_r;
            state_nxt = S_MUL;
          end
        end else if (idx_r == last_addr) begin
          // No segment holds x: take the last y
          tbl_done = 1'b1;
          tbl_val  = rd_y;
        end else begin
          prev_x_nxt = rd_x;
          prev_y_nxt = rd_y;
          idx_nxt    = idx_r + AW'(1);
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          tbl_done = 1'b1;
          tbl_val  = neg_r ? (y0_r - signed'(div_q)) : (y0_r + signed'(div_q));
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Store a finished table's value and move on
    if (tbl_done) begin
      if (!sel_r) begin
        eff_res_nxt = tbl_val;
        sel_nxt     = 1'b1;
        state_nxt   = S_TSTART;
      end else begin
        loss_res_nxt = tbl_val;
        state_nxt    = S_OUT;
      end
    end
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eff_cnt_r   <= '0;
      loss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      map_en_r    <= 1'b0;
      def_eff_r   <= DEF_EFF_RST;
      def_loss_r  <= DEF_LOSS_RST;
    end else begin
      state_r     <= state_nxt;
      eff_cnt_r   <= eff_cnt_nxt;
      loss_cnt_r  <= loss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= (state_r == S_MUL);
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_MAP_ENABLE: map_en_r   <= cfg_ch.data[0];
          CFG_DEF_EFF:    def_eff_r  <= signed'(cfg_ch.data);
          CFG_DEF_LOSS:   def_loss_r <= signed'(cfg_ch.data);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      action_r <= in_ch.action;
      tsel_r   <= in_ch.table_select;
      px_r     <= in_ch.point_x;
      py_r     <= in_ch.point_y;
      far_r    <= in_ch.fuel_air_ratio;
      cf_r     <= in_ch.corrected_flow;
    end
    sel_r      <= sel_nxt;
    idx_r      <= idx_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    y0_r       <= y0_nxt;
    dx_r       <= dx_nxt;
    den_r      <= den_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= dx_r * mag_r;
    eff_res_r  <= eff_res_nxt;
    loss_res_r <= loss_res_nxt;
    status_r   <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_eff_r    <= eff_res_r;
      out_loss_r   <= loss_res_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.efficiency    = out_eff_r;
  assign out_ch.pressure_loss = out_loss_r;

  `DTLI_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_ch.valid && in_ch.ready, state_r == S_DISPATCH, "accepted item did not reach dispatch")
  `DTLI_ASSERT_SAME(a_div_done_wait, clk, rst_n, div_done, state_r == S_DIV, "divider finished outside its wait state")
  `DTLI_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, (eff_cnt_r <= CNT_W'(MAX_POINTS)) && (loss_cnt_r <= CNT_W'(MAX_POINTS)), "table fill count beyond depth")
  `DTLI_ASSERT_NEXT(a_result_shown, clk, rst_n, out_load, out_ch.valid && (state_r == S_IDLE), "finished item not presented")

endmodule
`default_nettype wire
